[hdl/paa_pkg.sv]
`default_nettype none
package paa_pkg;

   localparam int QW   = 32;
   localparam int DVW  = 48;
   localparam int SUMW = 49;

   localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_READ  = 10'b00_0000_0010,
      ST_OFFS  = 10'b00_0000_0100,
      ST_SQMUL = 10'b00_0000_1000,
      ST_SQACC = 10'b00_0001_0000,
      ST_DCHK  = 10'b00_0010_0000,
      ST_DIVW  = 10'b00_0100_0000,
      ST_FORCE = 10'b00_1000_0000,
      ST_TMUL  = 10'b01_0000_0000,
      ST_TADD  = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic            start;
      logic [DVW-1:0]  dividend;
      logic [DVW-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DVW-1:0]  quotient;
   } div_rsp_type;

   // {flag, value}
   function automatic logic [QW:0] sat32(input logic signed [SUMW-1:0] v);
      logic [QW:0] r;
      if (v > SUMW'(Q_MAX)) begin
         r = {1'b1, Q_MAX};
      end else if (v < SUMW'(Q_MIN)) begin
         r = {1'b1, Q_MIN};
      end else begin
         r = {1'b0, v[QW-1:0]};
      end
      return r;
   endfunction

   function automatic logic [QW-1:0] mag32(input logic signed [QW-1:0] v);
      logic [QW-1:0] r;
      r = v[QW-1] ? (~v + 32'd1) : v;
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/paa_ram.sv]
`default_nettype none
module paa_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 8
) (
   input  wire logic                                        clock,
   input  wire logic                                        we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                            wdata,
   input  wire logic                                        re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

[hdl/paa_div.sv]
`default_nettype none
module paa_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire paa_pkg::div_req_type req,
   output paa_pkg::div_rsp_type      rsp
);
   localparam int W = paa_pkg::DVW;
   localparam int CNTW = $clog2(W);

   logic            busy_ff,  busy_in;
   logic            done_ff,  done_in;
   logic [CNTW-1:0] cnt_ff,   cnt_in;
   logic [W:0]      rem_ff,   rem_in;
   logic [W-1:0]    quo_ff,   quo_in;
   logic [W-1:0]    dsr_ff,   dsr_in;
   logic [W:0]      rem_sh;
   logic [W:0]      diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff[W-1:0], quo_ff[W-1]};
      diff    = rem_sh - {1'b0, dsr_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

[hdl/point_attractor_accel_accumulate.sv]
// Inverse-square point attractor accumulator, signed Q16.16. A load transaction
// (req_tuser = 1) writes one attractor entry and returns nothing. A particle
// transaction walks entries 0 .. min(count, MAX_ATTRACTORS)-1 and returns one
// response. The work per attractor is set mainly by the radix-2 divider (waiting
// on its 48 steps) and the single shared 32x32 multiplier (three squares and
// three terms). An attractor at zero squared distance skips the division. The
// finished response waits in the output register; if that register is still
// full, the walk holds in its last step until rsp_tready frees it.
// A new transaction is taken while the previous response still waits.
`default_nettype none
module point_attractor_accel_accumulate #(
   parameter int MAX_ATTRACTORS = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // entry_index[2:0], pos_x[34:3], pos_y[66:35], pos_z[98:67], strength[130:99],
   // acc_in_x[162:131], acc_in_y[194:163], acc_in_z[226:195], zero fill
   input  wire logic [231:0] req_tdata,
   input  wire logic [0:0]   req_tuser,   // action
   input  wire logic         req_tlast,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // acc_out_x[31:0], acc_out_y[63:32], acc_out_z[95:64]
   output logic      [95:0]  rsp_tdata,
   output logic      [0:0]   rsp_tuser,   // saturated
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic [3:0]   csr_wdata
);
   localparam int AW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
   localparam int CW = $clog2(MAX_ATTRACTORS + 1);
   localparam int NW = 7;
   localparam logic [NW-1:0] MAXN = NW'(MAX_ATTRACTORS);

   paa_pkg::state_type state_ff, state_in;

   logic [3:0]          count_ff, count_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [1:0]          lane_ff, lane_in;
   logic signed [31:0]  pos_ff [3];
   logic signed [31:0]  pos_in [3];
   logic signed [31:0]  acc_ff [3];
   logic signed [31:0]  acc_in [3];
   logic signed [31:0]  off_ff [3];
   logic signed [31:0]  off_in [3];
   logic signed [31:0]  s_ff, s_in;
   logic [63:0]         d2_ff, d2_in;
   logic [63:0]         prod_ff, prod_in;
   logic [31:0]         fmag_ff, fmag_in;
   logic                fneg_ff, fneg_in;
   logic                flag_ff, flag_in;
   logic                last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [95:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_sat_ff, rsp_sat_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_acc;
   logic                ram_we;
   logic                ram_re;
   logic [127:0]        ram_rdata;
   logic [NW-1:0]       n_eff;
   logic                j_last;
   logic [31:0]         mul_a;
   logic [31:0]         mul_b;
   logic [32:0]         st_tmp;
   logic signed [48:0]  t_ext;
   logic signed [48:0]  sum_ext;
   logic [47:0]         q;
   logic                rsp_free;

   paa_pkg::div_req_type div_req;
   paa_pkg::div_rsp_type div_rsp;

   assign req_tready = (state_ff == paa_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign ram_we     = req_acc && req_tuser[0] && ({4'd0, req_tdata[2:0]} < MAXN);
   assign ram_re     = (state_ff == paa_pkg::ST_READ);
   assign n_eff      = ({3'd0, count_ff} > MAXN) ? MAXN : {3'd0, count_ff};
   assign j_last     = (NW'(j_ff) + NW'(1)) == n_eff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign mul_a      = paa_pkg::mag32(off_ff[lane_ff]);
   assign mul_b      = (state_ff == paa_pkg::ST_SQMUL) ? mul_a : fmag_ff;
   assign q          = div_rsp.quotient;

   paa_ram #(.WIDTH(128), .DEPTH(MAX_ATTRACTORS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_tdata[2:0])),
      .wdata (req_tdata[130:3]),
      .re    (ram_re),
      .raddr (j_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   paa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_we ? csr_wdata : count_ff;
      j_in         = j_ff;
      lane_in      = lane_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      off_in       = off_ff;
      s_in         = s_ff;
      d2_in        = d2_ff;
      prod_in      = 64'(mul_a) * 64'(mul_b);
      fmag_in      = fmag_ff;
      fneg_in      = fneg_ff;
      flag_in      = flag_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {paa_pkg::mag32(s_ff), 16'd0};
      div_req.divisor  = d2_ff[63:16];
      st_tmp  = '0;
      t_ext   = '0;
      sum_ext = '0;

      case (state_ff)
         paa_pkg::ST_IDLE: begin
            if (req_acc && !req_tuser[0]) begin
               pos_in[0] = req_tdata[34:3];
               pos_in[1] = req_tdata[66:35];
               pos_in[2] = req_tdata[98:67];
               acc_in[0] = req_tdata[162:131];
               acc_in[1] = req_tdata[194:163];
               acc_in[2] = req_tdata[226:195];
               flag_in   = 1'b0;
               last_in   = req_tlast;
               j_in      = '0;
               state_in  = (n_eff == '0) ? paa_pkg::ST_TADD : paa_pkg::ST_READ;
               lane_in   = 2'd3;
            end
         end
         paa_pkg::ST_READ: begin
            state_in = paa_pkg::ST_OFFS;
         end
         paa_pkg::ST_OFFS: begin
            for (int k = 0; k < 3; k++) begin
               st_tmp = paa_pkg::sat32(49'(signed'(ram_rdata[32*k +: 32]))
                                     - 49'(pos_ff[k]));
               off_in[k] = st_tmp[31:0];
               flag_in   = flag_in | st_tmp[32];
            end
            s_in     = ram_rdata[127:96];
            d2_in    = '0;
            lane_in  = 2'd0;
            state_in = paa_pkg::ST_SQMUL;
         end
         paa_pkg::ST_SQMUL: begin
            state_in = paa_pkg::ST_SQACC;
         end
         paa_pkg::ST_SQACC: begin
            d2_in = d2_ff + prod_ff;
            if (lane_ff == 2'd2) begin
               state_in = paa_pkg::ST_DCHK;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = paa_pkg::ST_SQMUL;
            end
         end
         paa_pkg::ST_DCHK: begin
            lane_in = 2'd0;
            if (d2_ff[63:16] == '0) begin
               flag_in = 1'b1;
               fneg_in = s_ff[31];
               if (s_ff[31]) begin
                  fmag_in = 32'h8000_0000;
               end else if (s_ff != '0) begin
                  fmag_in = 32'h7FFF_FFFF;
               end else begin
                  fmag_in = '0;
               end
               state_in = paa_pkg::ST_TMUL;
            end else begin
               div_req.start = 1'b1;
               state_in      = paa_pkg::ST_DIVW;
            end
         end
         paa_pkg::ST_DIVW: begin
            if (div_rsp.done) begin
               state_in = paa_pkg::ST_FORCE;
            end
         end
         paa_pkg::ST_FORCE: begin
            fneg_in = s_ff[31] && (q != '0);
            if (s_ff[31]) begin
               if (q > 48'h0000_8000_0000) begin
                  fmag_in = 32'h8000_0000;
                  flag_in = 1'b1;
               end else begin
                  fmag_in = q[31:0];
               end
            end else begin
               if (q > 48'h0000_7FFF_FFFF) begin
                  fmag_in = 32'h7FFF_FFFF;
                  flag_in = 1'b1;
               end else begin
                  fmag_in = q[31:0];
               end
            end
            state_in = paa_pkg::ST_TMUL;
         end
         paa_pkg::ST_TMUL: begin
            state_in = paa_pkg::ST_TADD;
         end
         paa_pkg::ST_TADD: begin
            if (lane_ff != 2'd3) begin
               t_ext = {1'b0, prod_ff[63:16]};
               if (off_ff[lane_ff][31] != fneg_ff) begin
                  t_ext = -t_ext;
               end
               sum_ext = 49'(acc_ff[lane_ff]) + t_ext;
               st_tmp  = paa_pkg::sat32(sum_ext);
               acc_in[lane_ff] = st_tmp[31:0];
               flag_in = flag_ff | st_tmp[32];
            end
            if (lane_ff == 2'd0 || lane_ff == 2'd1) begin
               lane_in  = lane_ff + 2'd1;
               state_in = paa_pkg::ST_TMUL;
            end else if (lane_ff == 2'd2 && !j_last) begin
               j_in     = j_ff + CW'(1);
               state_in = paa_pkg::ST_READ;
            end else begin
               lane_in = 2'd3;
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {acc_in[2], acc_in[1], acc_in[0]};
                  rsp_sat_in   = flag_in;
                  rsp_last_in  = last_ff;
                  state_in     = paa_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = paa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= paa_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff        <= j_in;
      lane_ff     <= lane_in;
      pos_ff      <= pos_in;
      acc_ff      <= acc_in;
      off_ff      <= off_in;
      s_ff        <= s_in;
      d2_ff       <= d2_in;
      prod_ff     <= prod_in;
      fmag_ff     <= fmag_in;
      fneg_ff     <= fneg_in;
      flag_ff     <= flag_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == paa_pkg::ST_DIVW)
      else $error("divider finished outside its wait state");

   a_load_no_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) |=> state_ff == paa_pkg::ST_IDLE)
      else $error("load transaction started particle work");

   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(state_ff == paa_pkg::ST_TADD))
      else $error("response raised outside the final accumulate step");
endmodule
`default_nettype wire

[bench/point_attractor_accel_accumulate_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module point_attractor_accel_accumulate_tb;

   localparam int NUM_ENTRIES = 8;
   localparam logic ACT_PARTICLE = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   typedef struct packed {
      logic               action;
      logic [2:0]         entry_index;
      logic signed [31:0] pos_x, pos_y, pos_z, strength;
      logic signed [31:0] acc_x, acc_y, acc_z;
      logic               last;
   } item_type;

   typedef struct packed {
      logic signed [31:0] acc_x, acc_y, acc_z;
      logic               sat;
      logic               frame_end;
   } accel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [231:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tlast;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [3:0] csr_wdata = '0;

   point_attractor_accel_accumulate u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   item_type pending_items[$];
   accel_type expected_accels[$];
   logic signed [31:0] table_x[NUM_ENTRIES], table_y[NUM_ENTRIES];
   logic signed [31:0] table_z[NUM_ENTRIES], table_s[NUM_ENTRIES];
   int active_count = 0;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;

   function automatic logic signed [31:0] clamp32(input longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         flag = 1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic accel_type attract(input item_type it);
      accel_type r;
      longint acc[3], off[3], pos[3], at[3];
      longint s, force_q;
      logic [63:0] d2, q, t, dd;
      longint term;
      bit flag;
      int n;
      flag = 0;
      pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
      acc[0] = it.acc_x; acc[1] = it.acc_y; acc[2] = it.acc_z;
      n = active_count > NUM_ENTRIES ? NUM_ENTRIES : active_count;
      for (int j = 0; j < n; j++) begin
         at[0] = table_x[j]; at[1] = table_y[j]; at[2] = table_z[j];
         s = table_s[j];
         d2 = 0;
         for (int k = 0; k < 3; k++) begin
            off[k] = clamp32(at[k] - pos[k], flag);
            d2 += off[k] * off[k];
         end
         dd = d2 >> 16;
         if (dd == 0) begin
            flag = 1;
            force_q = s > 0 ? 64'sd2147483647 : (s < 0 ? -64'sd2147483648 : 0);
         end else begin
            q = ((s < 0 ? -s : s) << 16) / dd;
            force_q = s < 0 ? -longint'(q) : longint'(q);
            force_q = clamp32(force_q, flag);
         end
         for (int k = 0; k < 3; k++) begin
            t = ((off[k] < 0 ? -off[k] : off[k]) *
                 (force_q < 0 ? -force_q : force_q)) >> 16;
            term = ((off[k] < 0) != (force_q < 0)) ? -longint'(t) : longint'(t);
            acc[k] = clamp32(acc[k] + term, flag);
         end
      end
      r.acc_x = acc[0][31:0]; r.acc_y = acc[1][31:0]; r.acc_z = acc[2][31:0];
      r.sat = flag;
      r.frame_end = it.last;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            item_type it;
            it = pending_items.pop_front();
            req_tuser <= it.action;
            req_tlast <= it.last;
            req_tdata <= {5'b0, it.acc_z, it.acc_y, it.acc_x, it.strength,
                          it.pos_z, it.pos_y, it.pos_x, it.entry_index};
            req_tvalid <= 1'b1;
            if (it.action == ACT_LOAD) begin
               table_x[it.entry_index] = it.pos_x;
               table_y[it.entry_index] = it.pos_y;
               table_z[it.entry_index] = it.pos_z;
               table_s[it.entry_index] = it.strength;
            end else begin
               expected_accels.push_back(attract(it));
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver ready
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         accel_type got, want;
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                rsp_tuser[0], rsp_tlast};
         if (expected_accels.size() == 0) begin
            $display("%0t: unexpected transaction %h", $time, got);
            errors++;
         end else begin
            want = expected_accels.pop_front();
            if (got.acc_x !== want.acc_x || got.acc_y !== want.acc_y ||
                got.acc_z !== want.acc_z || got.sat !== want.sat ||
                got.frame_end !== want.frame_end) begin
               $display("%0t: mismatch expected %h %h %h sat %b last %b",
                        $time, want.acc_x, want.acc_y, want.acc_z, want.sat,
                        want.frame_end);
               $display("%0t:          actual   %h %h %h sat %b last %b",
                        $time, got.acc_x, got.acc_y, got.acc_z, got.sat,
                        got.frame_end);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_q(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
         default: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
      endcase
   endfunction

   function automatic item_type make_load(input int e, input int mode);
      item_type it;
      it = '0;
      it.action = ACT_LOAD;
      it.entry_index = 3'(e);
      it.pos_x = rand_q(mode); it.pos_y = rand_q(mode); it.pos_z = rand_q(mode);
      it.strength = rand_q(mode);
      it.acc_x = $urandom; it.acc_y = $urandom; it.acc_z = $urandom;
      it.last = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic item_type make_particle(input int mode);
      item_type it;
      it = make_load($urandom_range(7), mode);
      it.action = ACT_PARTICLE;
      it.acc_x = rand_q(mode); it.acc_y = rand_q(mode); it.acc_z = rand_q(mode);
      return it;
   endfunction

   task automatic drain();
      while (pending_items.size() > 0 || req_tvalid || expected_accels.size() > 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_count(input int n);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= 4'(n);
      active_count = n;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      item_type it;
      int counts[6] = '{0, 8, 15, 1, 3, 2};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_count(8);
      // directed: load all entries, extremes and zero-distance
      for (int e = 0; e < NUM_ENTRIES; e++)
         pending_items.push_back(make_load(e, 2));
      it = make_load(0, 0);
      it.pos_x = 0; it.pos_y = 0; it.pos_z = 0; it.strength = 32'sh7FFFFFFF;
      pending_items.push_back(it);
      it.entry_index = 3'd1; it.strength = 32'sh80000000;
      it.pos_x = 32'sh7FFFFFFF; it.pos_y = 32'sh80000000;
      pending_items.push_back(it);
      it.entry_index = 3'd2; it.strength = 0; it.pos_x = 65536;
      pending_items.push_back(it);
      it = make_particle(2);
      it.pos_x = 0; it.pos_y = 0; it.pos_z = 0; it.last = 1'b1;
      pending_items.push_back(it);
      it.pos_x = 32'sh80000000; it.pos_y = 32'sh7FFFFFFF; it.pos_z = 32'sh80000000;
      it.acc_x = 32'sh7FFFFFFF; it.acc_y = 32'sh80000000; it.acc_z = 32'sh7FFFFFFF;
      it.last = 1'b0;
      pending_items.push_back(it);
      it.pos_x = 65536; it.pos_z = 0; it.pos_y = 0;
      pending_items.push_back(it);
      for (int i = 0; i < 4; i++) pending_items.push_back(make_particle(i % 3));
      drain();
      // random phases over count settings and idling mixes
      for (int ph = 0; ph < 6; ph++) begin
         write_count(counts[ph]);
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 66 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 66 : (ph % 4 == 3 ? 33 : 0);
         if (ph % 4 == 3) send_idle_pct = 33;
         for (int i = 0; i < 220; i++) begin
            if ($urandom_range(9) == 0)
               pending_items.push_back(make_load($urandom_range(7), $urandom_range(2)));
            else
               pending_items.push_back(make_particle($urandom_range(2)));
         end
         if (ph == 1) hold_cycles = 3000;
         drain();
      end
      if (errors == 0) begin
         $display("point_attractor_accel_accumulate_tb passed");
      end else begin
         $display("point_attractor_accel_accumulate_tb failed");
      end
      $finish;
   end

   initial begin
      #(64'd8 * 64'd1_000_000 * 10);
      $display("point_attractor_accel_accumulate_tb failed");
      $finish;
   end

endmodule
`default_nettype wire

[point_attractor_accel_accumulate.f]
hdl/paa_pkg.sv
hdl/paa_ram.sv
hdl/paa_div.sv
hdl/point_attractor_accel_accumulate.sv
bench/point_attractor_accel_accumulate_tb.sv
